FILE: hdl/tpi_pkg.sv
package tpi_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int LANES       = 4;
  localparam int STEP_W      = 6;
  localparam int MUL_LAST    = 31;
  localparam int DIV_LAST    = 63;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_CLEAR  = 2'd1,
    REQ_EVAL   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_ORDER = 3'd2,
    ST_FEW   = 3'd3,
    ST_RANGE = 3'd4
  } status_t;

  // memory read address source
  typedef enum logic [2:0] {
    RD_MID,
    RD_LO_M1,
    RD_LO,
    RD_LAST,
    RD_FIRST
  } rd_sel_t;

  // what the result register takes
  typedef enum logic [1:0] {
    RES_CODE,
    RES_POINT,
    RES_INTERP
  } res_t;

  typedef struct packed {
    logic [31:0]            tm;
    logic [LANES-1:0][31:0] v;
  } entry_t;

  typedef struct packed {
    logic    decide;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    srch_step;
    logic    ld_left;
    logic    ld_right;
    logic    mul_step;
    logic    div_step;
    logic    res_ld;
    res_t    res_kind;
  } cmd_t;

  typedef struct packed {
    logic eval_go;
    logic srch_done;
    logic lo_zero;
    logic lo_end;
    logic out_busy;
  } sts_t;

endpackage

FILE: hdl/tpi_ctrl.sv
module tpi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          latch,
  output tpi_pkg::cmd_t cmd,
  input  tpi_pkg::sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_SRCH, S_SRCH_CMP, S_NB_A, S_NB_B, S_MUL, S_DIV, S_FIN
  } state_t;

  state_t                     state_r, state_nxt;
  tpi_pkg::res_t              kind_r, kind_nxt;
  logic [tpi_pkg::STEP_W-1:0] step_r, step_nxt;

  assign in_stall = (state_r != S_IDLE);
  assign latch    = in_valid && (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    step_nxt     = step_r;
    cmd          = '0;
    cmd.rd_sel   = tpi_pkg::RD_MID;
    cmd.res_kind = kind_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.eval_go) begin
          state_nxt = S_SRCH;
        end else begin
          kind_nxt  = tpi_pkg::RES_CODE;
          state_nxt = S_FIN;
        end
      end
      S_SRCH: begin
        cmd.rd_en = 1'b1;
        if (!sts.srch_done) begin
          state_nxt = S_SRCH_CMP;
        end else if (sts.lo_end) begin
          cmd.rd_sel = tpi_pkg::RD_LAST;
          kind_nxt   = tpi_pkg::RES_POINT;
          state_nxt  = S_FIN;
        end else if (sts.lo_zero) begin
          cmd.rd_sel = tpi_pkg::RD_FIRST;
          kind_nxt   = tpi_pkg::RES_POINT;
          state_nxt  = S_FIN;
        end else begin
          cmd.rd_sel = tpi_pkg::RD_LO_M1;
          state_nxt  = S_NB_A;
        end
      end
      S_SRCH_CMP: begin
        cmd.srch_step = 1'b1;
        state_nxt     = S_SRCH;
      end
      S_NB_A: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = tpi_pkg::RD_LO;
        cmd.ld_left = 1'b1;
        state_nxt   = S_NB_B;
      end
      S_NB_B: begin
        cmd.ld_right = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == tpi_pkg::STEP_W'(tpi_pkg::MUL_LAST)) begin
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == tpi_pkg::STEP_W'(tpi_pkg::DIV_LAST)) begin
          kind_nxt  = tpi_pkg::RES_INTERP;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.res_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= tpi_pkg::RES_CODE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

FILE: hdl/tpi_dp.sv
module tpi_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [15:0]              cfg_wr_data,
  input  logic                     latch,
  input  logic [1:0]               in_req_type,
  input  logic [31:0]              in_point_time,
  input  logic signed [31:0]       in_point_distance,
  input  logic signed [31:0]       in_point_speed,
  input  logic signed [31:0]       in_point_accel,
  input  logic signed [31:0]       in_point_jerk,
  input  tpi_pkg::cmd_t            cmd,
  output tpi_pkg::sts_t            sts,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               out_status,
  output logic [31:0]              out_time,
  output logic signed [31:0]       out_distance,
  output logic signed [31:0]       out_speed,
  output logic signed [31:0]       out_accel,
  output logic signed [31:0]       out_jerk,
  output logic [6:0]               out_point_count,
  output logic [31:0]              out_total_span
);

  localparam int AW = tpi_pkg::ADDR_W;
  localparam int CW = tpi_pkg::CNT_W;
  localparam int NL = tpi_pkg::LANES;

  logic [15:0]          tol_r;
  tpi_pkg::req_t        req_r;
  logic [31:0]          t_r;
  logic [NL-1:0][31:0]  v_r;
  logic [CW-1:0]        cnt_r;
  logic [31:0]          first_r, last_r;
  tpi_pkg::status_t     status_r;
  logic [CW-1:0]        lo_r, hi_r;
  logic [AW-1:0]        mid_r;
  tpi_pkg::entry_t      mem [tpi_pkg::TABLE_DEPTH];
  tpi_pkg::entry_t      rd_q;
  logic [31:0]          t0_r, span_r, mplr_r;
  logic [NL-1:0][31:0]  lane_res;
  logic                 out_valid_r;

  tpi_pkg::status_t     code;
  logic                 full, range_bad, wr_ok;
  logic [32:0]          tol33;
  logic [CW:0]          mid_sum;
  logic [AW-1:0]        mid_c, rd_addr;
  logic [CW-1:0]        lo_m1, cnt_m1;

  // request check
  assign full    = (cnt_r == CW'(tpi_pkg::TABLE_DEPTH));
  assign tol33   = {17'b0, tol_r};
  assign range_bad = ({1'b0, first_r} > {1'b0, t_r} + tol33) ||
                     ({1'b0, t_r} > {1'b0, last_r} + tol33);
  always_comb begin
    case (req_r)
      tpi_pkg::REQ_APPEND: begin
        if (full) code = tpi_pkg::ST_FULL;
        else if (cnt_r != '0 && t_r <= last_r) code = tpi_pkg::ST_ORDER;
        else code = tpi_pkg::ST_OK;
      end
      tpi_pkg::REQ_EVAL: begin
        if (cnt_r < CW'(2)) code = tpi_pkg::ST_FEW;
        else if (range_bad) code = tpi_pkg::ST_RANGE;
        else code = tpi_pkg::ST_OK;
      end
      default: code = tpi_pkg::ST_OK;
    endcase
  end
  assign wr_ok = cmd.decide && (req_r == tpi_pkg::REQ_APPEND) && (code == tpi_pkg::ST_OK);

  // search midpoint and read address
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_c   = mid_sum[AW:1];
  assign lo_m1   = lo_r - 1'b1;
  assign cnt_m1  = cnt_r - 1'b1;
  always_comb begin
    case (cmd.rd_sel)
      tpi_pkg::RD_MID:   rd_addr = mid_c;
      tpi_pkg::RD_LO_M1: rd_addr = lo_m1[AW-1:0];
      tpi_pkg::RD_LO:    rd_addr = lo_r[AW-1:0];
      tpi_pkg::RD_LAST:  rd_addr = cnt_m1[AW-1:0];
      default:           rd_addr = '0;
    endcase
  end

  assign sts.eval_go   = (req_r == tpi_pkg::REQ_EVAL) && (code == tpi_pkg::ST_OK);
  assign sts.srch_done = (lo_r >= hi_r);
  assign sts.lo_zero   = (lo_r == '0);
  assign sts.lo_end    = (lo_r == cnt_r);
  assign sts.out_busy  = out_valid_r && out_stall;

  // point table
  always_ff @(posedge clk) begin
    if (wr_ok) mem[cnt_r[AW-1:0]] <= '{tm: t_r, v: v_r};
    if (cmd.rd_en) rd_q <= mem[rd_addr];
  end

  // control state: tolerance and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cfg_wr_en) tol_r <= cfg_wr_data;
      if (wr_ok) cnt_r <= cnt_r + 1'b1;
      else if (cmd.decide && req_r == tpi_pkg::REQ_CLEAR) cnt_r <= '0;
    end
  end

  // request, end time, search and interval registers
  always_ff @(posedge clk) begin
    if (latch) begin
      req_r <= tpi_pkg::req_t'(in_req_type);
      t_r   <= in_point_time;
      v_r   <= {in_point_jerk, in_point_accel, in_point_speed, in_point_distance};
    end
    if (wr_ok) begin
      if (cnt_r == '0) first_r <= t_r;
      last_r <= t_r;
    end
    if (cmd.decide) begin
      status_r <= code;
      lo_r     <= '0;
      hi_r     <= cnt_r;
    end
    if (cmd.rd_en && cmd.rd_sel == tpi_pkg::RD_MID) mid_r <= mid_c;
    if (cmd.srch_step) begin
      if (rd_q.tm < t_r) lo_r <= {1'b0, mid_r} + 1'b1;
      else hi_r <= {1'b0, mid_r};
    end
    if (cmd.ld_left) t0_r <= rd_q.tm;
    if (cmd.ld_right) begin
      span_r <= rd_q.tm - t0_r;
      mplr_r <= t_r - t0_r;
    end
    if (cmd.mul_step) mplr_r <= {mplr_r[30:0], 1'b0};
  end

  // lanes: shift-add multiply by dt, then restoring divide by span
  for (genvar l = 0; l < NL; l++) begin : g_lane
    logic [31:0] x0_r, mag_r, q_r;
    logic        neg_r;
    logic [63:0] acc_r;
    logic [32:0] rem_r, diff, rem_sh;

    assign diff   = {rd_q.v[l][31], rd_q.v[l]} - {x0_r[31], x0_r};
    assign rem_sh = {rem_r[31:0], acc_r[63]};
    assign lane_res[l] = neg_r ? (x0_r - q_r) : (x0_r + q_r);

    always_ff @(posedge clk) begin
      if (cmd.ld_left) x0_r <= rd_q.v[l];
      if (cmd.ld_right) begin
        neg_r <= diff[32];
        mag_r <= diff[32] ? 32'(-diff) : diff[31:0];
        acc_r <= '0;
        rem_r <= '0;
        q_r   <= '0;
      end
      if (cmd.mul_step)
        acc_r <= {acc_r[62:0], 1'b0} + (mplr_r[31] ? {32'b0, mag_r} : 64'b0);
      if (cmd.div_step) begin
        acc_r <= {acc_r[62:0], 1'b0};
        if (rem_sh >= {1'b0, span_r}) begin
          rem_r <= rem_sh - {1'b0, span_r};
          q_r   <= {q_r[30:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          q_r   <= {q_r[30:0], 1'b0};
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      out_status      <= status_r;
      out_point_count <= 7'(cnt_r);
      out_total_span  <= (cnt_r == '0) ? 32'b0 : (last_r - first_r);
      case (cmd.res_kind)
        tpi_pkg::RES_POINT: begin
          out_time     <= rd_q.tm;
          out_distance <= rd_q.v[0];
          out_speed    <= rd_q.v[1];
          out_accel    <= rd_q.v[2];
          out_jerk     <= rd_q.v[3];
        end
        tpi_pkg::RES_INTERP: begin
          out_time     <= t_r;
          out_distance <= lane_res[0];
          out_speed    <= lane_res[1];
          out_accel    <= lane_res[2];
          out_jerk     <= lane_res[3];
        end
        default: begin
          out_time     <= '0;
          out_distance <= '0;
          out_speed    <= '0;
          out_accel    <= '0;
          out_jerk     <= '0;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(tpi_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");
  a_res_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_ld |=> out_valid_r)
    else $error("loaded result not presented");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_ld |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");
  a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (first_r <= last_r))
    else $error("first time after last time");

endmodule

FILE: hdl/timed_profile_interpolator.sv
// channel   direction  handshake              fields
// in_       input      in_valid / in_stall    req_type, point_time, distance..jerk
// out_      output     out_valid / out_stall  status, time, values, count, span
// cfg_      input      cfg_wr_en              cfg_wr_data (time tolerance)
//
// One item at a time. Append, clear, the unused code and failed evaluations
// pass from accept through a decide state to the result register. An evaluation with s
// search steps (s <= ceil(log2(count+1)), a read and a compare each) gives an end point,
// or an interpolated point after two neighbor reads, a shift-add multiply and a
// restoring divide in each of four parallel lanes.
// Reset clears count, tolerance and control; the table holds no reset value.
module timed_profile_interpolator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic [31:0]        in_point_time,
  input  logic signed [31:0] in_point_distance,
  input  logic signed [31:0] in_point_speed,
  input  logic signed [31:0] in_point_accel,
  input  logic signed [31:0] in_point_jerk,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [31:0]        out_time,
  output logic signed [31:0] out_distance,
  output logic signed [31:0] out_speed,
  output logic signed [31:0] out_accel,
  output logic signed [31:0] out_jerk,
  output logic [6:0]         out_point_count,
  output logic [31:0]        out_total_span
);

  tpi_pkg::cmd_t cmd;
  tpi_pkg::sts_t sts;
  logic          latch;

  tpi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .latch    (latch),
    .cmd      (cmd),
    .sts      (sts)
  );

  tpi_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .latch             (latch),
    .in_req_type       (in_req_type),
    .in_point_time     (in_point_time),
    .in_point_distance (in_point_distance),
    .in_point_speed    (in_point_speed),
    .in_point_accel    (in_point_accel),
    .in_point_jerk     (in_point_jerk),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_time          (out_time),
    .out_distance      (out_distance),
    .out_speed         (out_speed),
    .out_accel         (out_accel),
    .out_jerk          (out_jerk),
    .out_point_count   (out_point_count),
    .out_total_span    (out_total_span)
  );

endmodule
